/* src/tpq_pkg.sv */
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared types and constants for the timing-pair qualifier with top-two
// selection per board.
// ----------------------------------------------------------------------------
package tpq_pkg;

	// Field widths fixed by the interface.
	localparam int TAC_W   = 12;
	localparam int SUM_W   = 13;
	localparam int BOARD_W = 2;
	localparam int POS_W   = 3;
	localparam int IDX_W   = 4;
	localparam int CFG_IDX_W = 2;

	// Number of ranked pair positions on each board.
	localparam int PAIRS_PER_BOARD = 8;

	// Default number of boards with tracking state.
	localparam int BOARD_COUNT_DEF = 4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TAC_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAC_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TAC_DIFF = 2'd2;

	// Configuration reset values.
	localparam logic [TAC_W-1:0] TAC_LOW_RST  = 12'd0;
	localparam logic [TAC_W-1:0] TAC_HIGH_RST = 12'd4095;
	localparam logic [TAC_W-1:0] TAC_DIFF_RST = 12'd4095;

	// Qualification window and difference limit.
	typedef struct packed {
		logic [TAC_W-1:0] low;
		logic [TAC_W-1:0] high;
		logic [TAC_W-1:0] diff;
	} cfg_t;

	// Outcome of the pair checks.
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             accepted;
	} qual_t;

	// Top-two tracking state of one board.
	typedef struct packed {
		logic [SUM_W-1:0] best_sum;
		logic [SUM_W-1:0] second_sum;
		logic [IDX_W-1:0] best_idx;
		logic [IDX_W-1:0] second_idx;
	} rank_entry_t;

endpackage

/* src/tpq_qualify.sv */
// ----------------------------------------------------------------------------
// tpq_qualify
// Window and difference checks on one timing pair, and the pair sum.
// ----------------------------------------------------------------------------
module tpq_qualify import tpq_pkg::*; (
	input  cfg_t             cfg,
	input  logic [TAC_W-1:0] tac_a,
	input  logic [TAC_W-1:0] tac_b,
	output qual_t            qual
);

	logic [TAC_W-1:0] diff;
	logic             a_in_win;
	logic             b_in_win;
	logic             ok;

	// Absolute difference of the two values.
	assign diff = (tac_a > tac_b) ? (tac_a - tac_b) : (tac_b - tac_a);

	// Both members must lie inside the window; an inverted window rejects all.
	assign a_in_win = (tac_a >= cfg.low) && (tac_a <= cfg.high);
	assign b_in_win = (tac_b >= cfg.low) && (tac_b <= cfg.high);
	assign ok       = a_in_win && b_in_win && (diff <= cfg.diff);

	// A rejected pair yields a zero sum.
	assign qual.accepted = ok;
	assign qual.sum      = ok ? ({1'b0, tac_a} + {1'b0, tac_b}) : '0;

endmodule

/* src/tpq_rank.sv */
// ----------------------------------------------------------------------------
// tpq_rank
// Per-board tracking of the largest and second-largest pair sums and their
// positions, updated by one read-modify-write per transfer.
// ----------------------------------------------------------------------------
module tpq_rank import tpq_pkg::*; #(
	parameter int BOARD_COUNT = BOARD_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               upd_en,
	input  logic [BOARD_W-1:0] board,
	input  logic [POS_W-1:0]   pos,
	input  logic [SUM_W-1:0]   sum,
	output logic [IDX_W-1:0]   best_pos,
	output logic [IDX_W-1:0]   second_pos
);

	rank_entry_t            entry_q [BOARD_COUNT];
	logic [BOARD_COUNT-1:0] hit;
	rank_entry_t            cur;
	rank_entry_t            base;
	rank_entry_t            nxt;
	logic                   in_range;
	logic                   ranked;
	logic [IDX_W-1:0]       one_based;

	// Board decode and selection of the addressed entry.
	always_comb begin
		cur = '0;
		for (int b = 0; b < BOARD_COUNT; b++) begin
			hit[b] = (32'(board) == b);
			if (hit[b]) begin
				cur = entry_q[b];
			end
		end
	end

	assign in_range  = (32'(board) < BOARD_COUNT);
	assign ranked    = (32'(pos) < PAIRS_PER_BOARD);
	assign one_based = {1'b0, pos} + 4'd1;

	// Restart clears the entry before ranking; strict compares keep ties.
	always_comb begin
		base = (pos == '0) ? '0 : cur;
		nxt  = base;
		if (ranked) begin
			if (sum > base.best_sum) begin
				nxt.second_sum = base.best_sum;
				nxt.second_idx = base.best_idx;
				nxt.best_sum   = sum;
				nxt.best_idx   = one_based;
			end else if (sum > base.second_sum) begin
				nxt.second_sum = sum;
				nxt.second_idx = one_based;
			end
		end
	end

	// Reported positions come from the updated entry.
	assign best_pos   = in_range ? nxt.best_idx : '0;
	assign second_pos = in_range ? nxt.second_idx : '0;

	// State write-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BOARD_COUNT; b++) begin
				entry_q[b] <= '0;
			end
		end else if (upd_en) begin
			for (int b = 0; b < BOARD_COUNT; b++) begin
				if (hit[b]) begin
					entry_q[b] <= nxt;
				end
			end
		end
	end

	// The best sum never falls below the second sum.
	a_sum_order: assert property (@(posedge clk) disable iff (!arst_n)
		cur.best_sum >= cur.second_sum)
		else $error("best sum below second sum");

	// A second position is only held once a best position exists.
	a_idx_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cur.second_idx != '0) |-> (cur.best_idx != '0))
		else $error("second position without best position");

	// A nonzero best sum always has its position recorded.
	a_sum_has_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(cur.best_sum != '0) |-> (cur.best_idx != '0))
		else $error("best sum without position");

endmodule

/* src/tac_pair_qualify_top_two.sv */
// ----------------------------------------------------------------------------
// tac_pair_qualify_top_two
// Timing-pair qualifier with top-two selection of pair sums per board.
// ----------------------------------------------------------------------------
// The block takes one pair transfer in every clock cycle while in_stall is low
// and returns one result per pair: the pair is captured in an input register,
// then qualified, summed and ranked against its board's state and captured
// in the result register. The sustained rate of one pair per cycle is set by
// the per-board read-modify-write of the tracking state, which is written
// back as the pair enters the result register, so pairs for the same board
// may follow each other with no gap. Output stall holds the result register;
// the input register still takes a pair while it is empty. The user must
// write configuration through the plain write port only while no pair is in
// flight; the block does not enforce this. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module tac_pair_qualify_top_two import tpq_pkg::*; #(
	parameter int BOARD_COUNT = BOARD_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port.
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TAC_W-1:0]     cfg_wdata,
	// Input channel.
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BOARD_W-1:0]   board,
	input  logic [POS_W-1:0]     pair_position,
	input  logic [TAC_W-1:0]     tac_first,
	input  logic [TAC_W-1:0]     tac_second,
	// Output channel.
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [SUM_W-1:0]     pair_sum,
	output logic                 pair_accepted,
	output logic [IDX_W-1:0]     best_position,
	output logic [IDX_W-1:0]     second_position
);

	cfg_t               cfg_q;
	logic               valid_s1;
	logic [BOARD_W-1:0] board_s1;
	logic [POS_W-1:0]   pos_s1;
	logic [TAC_W-1:0]   tac_a_s1;
	logic [TAC_W-1:0]   tac_b_s1;
	logic               valid_s2;
	logic [SUM_W-1:0]   sum_s2;
	logic               accepted_s2;
	logic [IDX_W-1:0]   best_s2;
	logic [IDX_W-1:0]   second_s2;
	logic               advance;
	logic               in_xfer;
	qual_t              qual;
	logic [IDX_W-1:0]   best_pos;
	logic [IDX_W-1:0]   second_pos;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low  <= TAC_LOW_RST;
			cfg_q.high <= TAC_HIGH_RST;
			cfg_q.diff <= TAC_DIFF_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_TAC_LOW:  cfg_q.low  <= cfg_wdata;
				REG_TAC_HIGH: cfg_q.high <= cfg_wdata;
				REG_TAC_DIFF: cfg_q.diff <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Pipeline control: stage 1 moves on when the result register is free.
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			board_s1 <= board;
			pos_s1   <= pair_position;
			tac_a_s1 <= tac_first;
			tac_b_s1 <= tac_second;
		end
	end

	// Pair checks and sum.
	tpq_qualify u_qualify (
		.cfg   (cfg_q),
		.tac_a (tac_a_s1),
		.tac_b (tac_b_s1),
		.qual  (qual)
	);

	// Per-board ranking; state is updated when the pair leaves stage 1.
	tpq_rank #(
		.BOARD_COUNT (BOARD_COUNT)
	) u_rank (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd_en     (valid_s1 && advance),
		.board      (board_s1),
		.pos        (pos_s1),
		.sum        (qual.sum),
		.best_pos   (best_pos),
		.second_pos (second_pos)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			sum_s2      <= qual.sum;
			accepted_s2 <= qual.accepted;
			best_s2     <= best_pos;
			second_s2   <= second_pos;
		end
	end

	assign out_valid       = valid_s2;
	assign pair_sum        = sum_s2;
	assign pair_accepted   = accepted_s2;
	assign best_position   = best_s2;
	assign second_position = second_s2;

	// A rejected pair always reports a zero sum.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !accepted_s2) |-> (sum_s2 == '0))
		else $error("rejected pair with nonzero sum");

	// Input stall is only raised while stage 1 holds a pair.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty stage 1");

	// A pair held in stage 1 is not dropped while the output is stalled.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("stage 1 pair lost under stall");

endmodule

/* tb/sv/tac_pair_qualify_top_two_tb.sv */
// ----------------------------------------------------------------------------
// tac_pair_qualify_top_two_tb
// Self-checking bench for the timing-pair qualifier with top-two ranking.
// ----------------------------------------------------------------------------
// A short stimulus table walks the window edges, an inverted window, a zero
// difference limit, ties, restarts and full-scale sums. Random traffic follows
// in phases with different limits and pacing. Most of it is ordered position
// scans per board, and the rest is noise. Every transferred pair is ranked
// by a local model of the per-board state. Each result transfer is checked
// field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tac_pair_qualify_top_two_tb import tpq_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BOARDS     = BOARD_COUNT_DEF;
	localparam int CYCLE_CAP  = 200000;
	localparam int PHASES     = 8;
	localparam int PHASE_LEN  = 220;
	localparam int LONG_HOLD  = 300;

	typedef enum {PACE_FULL, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             accepted;
		logic [IDX_W-1:0] best;
		logic [IDX_W-1:0] second;
	} pair_result_t;

	typedef struct packed {
		cfg_t               lim;
		logic [BOARD_W-1:0] brd;
		logic [POS_W-1:0]   pos;
		logic [TAC_W-1:0]   first;
		logic [TAC_W-1:0]   second;
		logic               fixed;
		pair_result_t       res;
	} pair_row_t;

	localparam cfg_t LIM_FULL     = {12'd0,    12'd4095, 12'd4095};
	localparam cfg_t LIM_NARROW   = {12'd100,  12'd200,  12'd10};
	localparam cfg_t LIM_INVERTED = {12'd4095, 12'd0,    12'd0};
	localparam cfg_t LIM_TOP_ONLY = {12'd4095, 12'd4095, 12'd0};
	localparam cfg_t LIM_NO_DIFF  = {12'd0,    12'd4095, 12'd0};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_TAC_LOW;
	logic [TAC_W-1:0]     cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [BOARD_W-1:0]   board = '0;
	logic [POS_W-1:0]     pair_position = '0;
	logic [TAC_W-1:0]     tac_first = '0;
	logic [TAC_W-1:0]     tac_second = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [SUM_W-1:0]     pair_sum;
	logic                 pair_accepted;
	logic [IDX_W-1:0]     best_position;
	logic [IDX_W-1:0]     second_position;

	// Local copy of the limits and of the per-board ranking state.
	cfg_t             limits = LIM_FULL;
	logic [SUM_W-1:0] top_sum    [BOARDS];
	logic [SUM_W-1:0] runner_sum [BOARDS];
	logic [IDX_W-1:0] top_pos    [BOARDS];
	logic [IDX_W-1:0] runner_pos [BOARDS];

	pair_result_t pending_results[$];
	pair_result_t oldest_result;
	pair_row_t    pair_table[$];
	int           next_scan_pos[BOARDS];
	int           fail_count = 0;
	int           cycle_count = 0;
	int           sender_idle_pct = 0;
	int           receiver_stall_pct = 0;
	int           hold_request = 0;
	int           hold_left = 0;

	tac_pair_qualify_top_two dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.board           (board),
		.pair_position   (pair_position),
		.tac_first       (tac_first),
		.tac_second      (tac_second),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pair_sum        (pair_sum),
		.pair_accepted   (pair_accepted),
		.best_position   (best_position),
		.second_position (second_position)
	);

	// Free-running clock with a 2 ns period.
	initial begin
		forever #1 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Qualifies one pair against the current limits and ranks its sum on its board.
	function automatic pair_result_t rank_pair(logic [BOARD_W-1:0] brd, logic [POS_W-1:0] pos,
			logic [TAC_W-1:0] a, logic [TAC_W-1:0] c);
		logic [TAC_W-1:0] spread;
		logic [IDX_W-1:0] slot;
		logic             ok;
		pair_result_t     r;
		spread = (a > c) ? a - c : c - a;
		ok = a >= limits.low && a <= limits.high && c >= limits.low && c <= limits.high &&
			spread <= limits.diff;
		r.sum = ok ? {1'b0, a} + {1'b0, c} : '0;
		r.accepted = ok;
		r.best = '0;
		r.second = '0;
		if (brd < BOARDS) begin
			if (pos == 0) begin
				top_sum[brd] = '0;
				runner_sum[brd] = '0;
				top_pos[brd] = '0;
				runner_pos[brd] = '0;
			end
			if (pos < PAIRS_PER_BOARD) begin
				slot = {1'b0, pos} + 4'd1;
				// Strictly greater, so ties keep the earlier position.
				if (r.sum > top_sum[brd]) begin
					runner_sum[brd] = top_sum[brd];
					runner_pos[brd] = top_pos[brd];
					top_sum[brd] = r.sum;
					top_pos[brd] = slot;
				end else if (r.sum > runner_sum[brd]) begin
					runner_sum[brd] = r.sum;
					runner_pos[brd] = slot;
				end
			end
			r.best = top_pos[brd];
			r.second = runner_pos[brd];
		end
		return r;
	endfunction

	function automatic pair_row_t table_row(cfg_t lim, int brd, int pos, int a, int c,
			bit fixed, int sum, int acc, int bp, int sp);
		pair_row_t row;
		row.lim = lim;
		row.brd = BOARD_W'(brd);
		row.pos = POS_W'(pos);
		row.first = TAC_W'(a);
		row.second = TAC_W'(c);
		row.fixed = fixed;
		row.res.sum = SUM_W'(sum);
		row.res.accepted = 1'(acc);
		row.res.best = IDX_W'(bp);
		row.res.second = IDX_W'(sp);
		return row;
	endfunction

	task automatic check_field(string field, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
			fail_count++;
		end
	endtask

	task automatic set_pace(pace_t pace);
		sender_idle_pct = (pace == PACE_SENDER_IDLE) ? 48 : (pace == PACE_BOTH) ? 6 : 0;
		receiver_stall_pct = (pace == PACE_RECEIVER_STALL) ? 48 : (pace == PACE_BOTH) ? 6 : 0;
	endtask

	// Result side: check every transfer, then choose the stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result transfer with nothing pending: sum %0d", $time,
						pair_sum);
					fail_count++;
				end else begin
					oldest_result = pending_results.pop_front();
					check_field("pair_sum", oldest_result.sum, pair_sum);
					check_field("pair_accepted", SUM_W'(oldest_result.accepted),
						SUM_W'(pair_accepted));
					check_field("best_position", SUM_W'(oldest_result.best),
						SUM_W'(best_position));
					check_field("second_position", SUM_W'(oldest_result.second),
						SUM_W'(second_position));
				end
			end
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
			end
		end
	end

	// Offers one pair, waits for its transfer and queues the prediction.
	task automatic send_pair(logic [BOARD_W-1:0] brd, logic [POS_W-1:0] pos,
			logic [TAC_W-1:0] a, logic [TAC_W-1:0] c, bit fixed, pair_result_t fixed_res);
		pair_result_t predicted;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			board <= BOARD_W'($urandom);
			pair_position <= POS_W'($urandom);
			tac_first <= TAC_W'($urandom);
			tac_second <= TAC_W'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		board <= brd;
		pair_position <= pos;
		tac_first <= a;
		tac_second <= c;
		do @(posedge clk); while (in_stall);
		predicted = rank_pair(brd, pos, a, c);
		pending_results.push_back(fixed ? fixed_res : predicted);
	endtask

	// Stops offering and waits until every pending result has been returned.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes all three limit registers, one per cycle, while the block is idle.
	task automatic write_limits(cfg_t lim);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_TAC_LOW;
		cfg_wdata <= lim.low;
		@(posedge clk);
		cfg_index <= REG_TAC_HIGH;
		cfg_wdata <= lim.high;
		@(posedge clk);
		cfg_index <= REG_TAC_DIFF;
		cfg_wdata <= lim.diff;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		limits = lim;
	endtask

	// Mostly ordered position scans with values near the window, plus noise.
	task automatic send_random_pair();
		int           brd;
		int           pos;
		int           lo;
		int           hi;
		int           a;
		int           c;
		int           off;
		pair_result_t none;
		none = '0;
		lo = int'(limits.low);
		hi = int'(limits.high);
		if ($urandom_range(0, 99) < 85) begin
			brd = $urandom_range(0, BOARDS - 1);
			if ($urandom_range(0, 99) < 8) next_scan_pos[brd] = 0;
			pos = next_scan_pos[brd];
			next_scan_pos[brd] = (pos + 1) % PAIRS_PER_BOARD;
		end else begin
			brd = $urandom_range(0, 3);
			pos = $urandom_range(0, 7);
		end
		if (lo <= hi && $urandom_range(0, 99) < 75) begin
			a = $urandom_range(hi, lo);
			off = $urandom_range(0, limits.diff + 2);
			c = $urandom_range(0, 1) ? a + off : a - off;
			if (c < 0) c = 0;
			if (c > 4095) c = 4095;
		end else begin
			a = $urandom_range(0, 4095);
			c = $urandom_range(0, 4095);
		end
		send_pair(BOARD_W'(brd), POS_W'(pos), TAC_W'(a), TAC_W'(c), 1'b0, none);
	endtask

	// Stimulus: reset, the directed table, then the random phases.
	initial begin
		cfg_t lim;
		int   lo;
		for (int b = 0; b < BOARDS; b++) begin
			top_sum[b] = '0;
			runner_sum[b] = '0;
			top_pos[b] = '0;
			runner_pos[b] = '0;
			next_scan_pos[b] = 0;
		end

		// Full window: zero pair, full-scale pair, ties on best and second, restarts.
		pair_table.push_back(table_row(LIM_FULL, 0, 0, 0, 0, 1, 0, 1, 0, 0));
		pair_table.push_back(table_row(LIM_FULL, 0, 1, 4095, 4095, 1, 8190, 1, 2, 0));
		pair_table.push_back(table_row(LIM_FULL, 0, 2, 4095, 0, 1, 4095, 1, 2, 3));
		pair_table.push_back(table_row(LIM_FULL, 0, 3, 0, 4095, 1, 4095, 1, 2, 3));
		pair_table.push_back(table_row(LIM_FULL, 0, 7, 4095, 4095, 1, 8190, 1, 2, 8));
		pair_table.push_back(table_row(LIM_FULL, 1, 0, 100, 200, 1, 300, 1, 1, 0));
		pair_table.push_back(table_row(LIM_FULL, 1, 5, 2048, 2047, 1, 4095, 1, 6, 1));
		pair_table.push_back(table_row(LIM_FULL, 0, 0, 1, 2, 1, 3, 1, 1, 0));
		pair_table.push_back(table_row(LIM_FULL, 2, 4, 1, 1, 1, 2, 1, 5, 0));
		pair_table.push_back(table_row(LIM_FULL, 3, 6, 0, 0, 1, 0, 1, 0, 0));
		pair_table.push_back(table_row(LIM_FULL, 3, 7, 4095, 4095, 1, 8190, 1, 8, 0));
		pair_table.push_back(table_row(LIM_FULL, 1, 6, 10, 20, 0, 0, 0, 0, 0));
		// Narrow window: each edge and the difference limit, just in and just out.
		pair_table.push_back(table_row(LIM_NARROW, 2, 0, 100, 110, 1, 210, 1, 1, 0));
		pair_table.push_back(table_row(LIM_NARROW, 2, 1, 99, 100, 1, 0, 0, 1, 0));
		pair_table.push_back(table_row(LIM_NARROW, 2, 2, 200, 201, 1, 0, 0, 1, 0));
		pair_table.push_back(table_row(LIM_NARROW, 2, 3, 150, 161, 1, 0, 0, 1, 0));
		pair_table.push_back(table_row(LIM_NARROW, 2, 4, 200, 190, 1, 390, 1, 5, 1));
		// Inverted window rejects everything.
		pair_table.push_back(table_row(LIM_INVERTED, 0, 1, 4095, 4095, 1, 0, 0, 1, 0));
		pair_table.push_back(table_row(LIM_INVERTED, 1, 2, 0, 0, 0, 0, 0, 0, 0));
		// Window of a single value at the top of the range.
		pair_table.push_back(table_row(LIM_TOP_ONLY, 0, 2, 4095, 4095, 1, 8190, 1, 3, 1));
		pair_table.push_back(table_row(LIM_TOP_ONLY, 0, 3, 4094, 4095, 1, 0, 0, 3, 1));
		// Zero difference limit over the full window.
		pair_table.push_back(table_row(LIM_NO_DIFF, 3, 0, 5, 5, 1, 10, 1, 1, 0));
		pair_table.push_back(table_row(LIM_NO_DIFF, 3, 1, 5, 6, 1, 0, 0, 1, 0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_pace(PACE_FULL);
		foreach (pair_table[i]) begin
			if (pair_table[i].lim != limits) begin
				drain_results();
				write_limits(pair_table[i].lim);
			end
			send_pair(pair_table[i].brd, pair_table[i].pos, pair_table[i].first,
				pair_table[i].second, pair_table[i].fixed, pair_table[i].res);
		end

		// Random phases, each with its own limits and pacing.
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			case (ph)
				0, 7: lim = LIM_FULL;
				2: lim = LIM_NO_DIFF;
				3: lim = {12'd1000, 12'd1100, 12'd50};
				4: begin
					lo = $urandom_range(1, 4095);
					lim = {12'(lo), 12'($urandom_range(0, lo - 1)), 12'($urandom_range(0, 4095))};
				end
				5: lim = {12'd2000, 12'd4095, 12'd4095};
				default: begin
					lo = $urandom_range(0, 4095);
					lim = {12'(lo), 12'($urandom_range(lo, 4095)), 12'($urandom_range(0, 4095))};
				end
			endcase
			write_limits(lim);
			set_pace(pace_t'(ph % 4));
			for (int n = 0; n < PHASE_LEN; n++) begin
				// Long receiver hold-off while pairs keep coming, to fill the block.
				if ((ph == 1 || ph == 5) && n == 100) hold_request = LONG_HOLD;
				// Sender pause until every result is back, then carry on.
				if (ph == 6 && n == 150) drain_results();
				send_random_pair();
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
